>>> rtl/core/wall_column_texture_stepper_top_assert.svh
// assertion macros used by the stepper control module
`ifndef WALL_COLUMN_TEXTURE_STEPPER_TOP_ASSERT_SVH
`define WALL_COLUMN_TEXTURE_STEPPER_TOP_ASSERT_SVH

// same-cycle implication, off while reset is high
`define WCTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wcts same-cycle check failed");

// next-cycle implication, off while reset is high
`define WCTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wcts next-cycle check failed");

`endif

>>> rtl/core/wcts_pkg.sv
`timescale 1ns / 1ps
package wcts_pkg;

   localparam int SCREEN_ROWS      = 512;
   localparam int TEXTURE_ROWS_MAX = 1024;

   localparam int PC_W     = 32;
   localparam int TH_W     = 11;
   localparam int DIST_W   = 24;
   localparam int TCOL_W   = 10;
   localparam int SROW_W   = 9;
   localparam int TROW_W   = 10;
   localparam int ACC_W    = 26;
   localparam int FRAC_W   = 16;
   localparam int LEFT_W   = 10;
   localparam int QUO_W    = PC_W + 8;
   localparam int PROD_W   = ACC_W + 9;
   localparam int SCREEN_Q8 = SCREEN_ROWS * 256;
   localparam int Q8_W     = $clog2(SCREEN_Q8) + 1;

   localparam int DIV_STEPS = QUO_W;
   localparam int MUL_STEPS = ACC_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [PC_W-1:0] PC_RESET = 32'd7260160;
   localparam logic [TH_W-1:0] TH_RESET = 11'd64;

   localparam logic REG_PROJECTION = 1'b0;
   localparam logic REG_TEX_HEIGHT = 1'b1;

   typedef struct packed {
      logic load_w;
      logic load_s;
      logic div_step;
      logic load_m;
      logic mul_step;
      logic commit;
      logic row_advance;
   } cmd_type;

   typedef struct packed {
      logic rows_zero;
   } status_type;

   function automatic logic [TH_W-1:0] th_effective(input logic [TH_W-1:0] th);
      logic [TH_W-1:0] r;
      r = th;
      if (th == '0) begin
         r = TH_W'(1);
      end else if (th > TH_W'(TEXTURE_ROWS_MAX)) begin
         r = TH_W'(TEXTURE_ROWS_MAX);
      end
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] sat_step(input logic [QUO_W-1:0] q);
      logic [ACC_W-1:0] r;
      r = q[ACC_W-1:0];
      if (q[QUO_W-1:ACC_W] != '0) begin
         r = {ACC_W{1'b1}};
      end
      return r;
   endfunction

endpackage

>>> rtl/core/wcts_req_if.sv
`timescale 1ns / 1ps
interface wcts_req_if;
   import wcts_pkg::*;
   logic                valid;
   logic                ready;
   logic                mode;
   logic [DIST_W-1:0]   ray_distance;
   logic [TCOL_W-1:0]   texture_column;
   modport source (output valid, mode, ray_distance, texture_column, input ready);
   modport sink   (input valid, mode, ray_distance, texture_column, output ready);
endinterface

>>> rtl/core/wcts_rsp_if.sv
`timescale 1ns / 1ps
interface wcts_rsp_if;
   import wcts_pkg::*;
   logic                valid;
   logic                ready;
   logic [SROW_W-1:0]   screen_row;
   logic [TROW_W-1:0]   texture_row;
   logic [TCOL_W-1:0]   column_of_texture;
   logic                last;
   modport source (output valid, screen_row, texture_row, column_of_texture, last,
                   input ready);
   modport sink   (input valid, screen_row, texture_row, column_of_texture, last,
                   output ready);
endinterface

>>> rtl/core/wall_column_texture_stepper_top.sv
`timescale 1ns / 1ps
// wall column texture stepper
// req_bus (valid/ready): mode 0 opens a screen column from ray_distance and
//   texture_column; mode 1 asks for the next wall row of that column.
// rsp_bus (valid/ready): one beat per row request while rows remain, carrying
//   screen_row, texture_row, column_of_texture and last on the final row.
//   a row request after the last row is taken and gives no beat.
// csr port (apb-style): projection_constant at 0x0, texture_height at 0x4.
// a row beat is registered and appears on rsp_bus in the cycle after its request.
// throughput: row requests go one per cycle while the output register drains.
//   a column start holds req ready low through two 40-step restoring divisions
//   (wall height, texture step), a 26-step shift-add multiply for the clip
//   offset plus load_s, load_m and commit states, on one bit-serial datapath.
// reset: csr registers return to their defaults, no column is open and the
//   output register is empty.
// when the receiver stalls, the pending beat holds and req ready stays low
//   until it is taken.
module wall_column_texture_stepper_top (
   input  logic                                 clock,
   input  logic                                 reset,
   wcts_req_if.sink                             req_bus,
   wcts_rsp_if.source                           rsp_bus,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [wcts_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [wcts_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [wcts_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import wcts_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic [TH_W-1:0] th_ff, th_in;
   logic            csr_write;
   cmd_type         cmd;
   status_type      status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      pc_in = pc_ff;
      th_in = th_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_PROJECTION: pc_in = csr_pwdata;
            REG_TEX_HEIGHT: th_in = csr_pwdata[TH_W-1:0];
            default:        pc_in = pc_ff;
         endcase
      end
      case (csr_paddr[2])
         REG_PROJECTION: csr_prdata = pc_ff;
         REG_TEX_HEIGHT: csr_prdata = CSR_DATA_W'(th_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_RESET;
         th_ff <= TH_RESET;
      end else begin
         pc_ff <= pc_in;
         th_ff <= th_in;
      end
   end

   wcts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_mode  (req_bus.mode),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wcts_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .projection_constant (pc_ff),
      .texture_height      (th_ff),
      .ray_distance        (req_bus.ray_distance),
      .texture_column      (req_bus.texture_column),
      .screen_row          (rsp_bus.screen_row),
      .texture_row         (rsp_bus.texture_row),
      .column_of_texture   (rsp_bus.column_of_texture),
      .last                (rsp_bus.last)
   );

endmodule

>>> rtl/core/wcts_datapath.sv
`timescale 1ns / 1ps
module wcts_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  wcts_pkg::cmd_type                   cmd,
   output wcts_pkg::status_type                status,
   input  logic [wcts_pkg::PC_W-1:0]           projection_constant,
   input  logic [wcts_pkg::TH_W-1:0]           texture_height,
   input  logic [wcts_pkg::DIST_W-1:0]         ray_distance,
   input  logic [wcts_pkg::TCOL_W-1:0]         texture_column,
   output logic [wcts_pkg::SROW_W-1:0]         screen_row,
   output logic [wcts_pkg::TROW_W-1:0]         texture_row,
   output logic [wcts_pkg::TCOL_W-1:0]         column_of_texture,
   output logic                                last
);
   import wcts_pkg::*;

   // shared divider / multiplier working registers
   logic [QUO_W-1:0]  rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in, w_ff, w_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in, prod_ff, prod_in;
   logic [ACC_W-1:0]  mplier_ff, mplier_in;
   // column state
   logic [ACC_W-1:0]  acc_ff, acc_in, step_ff, step_in;
   logic [SROW_W-1:0] row_ff, row_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [TCOL_W-1:0] col_ff, col_in;
   // result register
   logic [SROW_W-1:0] srow_ff, srow_in;
   logic [TROW_W-1:0] trow_ff, trow_in;
   logic [TCOL_W-1:0] tcol_ff, tcol_in;
   logic              last_ff, last_in;

   logic [QUO_W:0]    shifted, diff;
   logic              ge;
   logic [QUO_W-1:0]  mcand_src;
   logic [TH_W-1:0]   th_eff;
   logic [TROW_W-1:0] limit, acc_int;
   logic [ACC_W:0]    acc_sum;
   logic [Q8_W-1:0]   w_low;
   logic              clipped;

   always_comb begin
      th_eff    = th_effective(texture_height);
      limit     = TROW_W'(th_eff - TH_W'(1));
      acc_int   = acc_ff[ACC_W-1:FRAC_W];
      shifted   = {rem_ff, quo_ff[QUO_W-1]};
      diff      = shifted - {1'b0, dvs_ff};
      ge        = shifted >= {1'b0, dvs_ff};
      mcand_src = w_ff - QUO_W'(SCREEN_Q8);
      acc_sum   = {1'b0, acc_ff} + {1'b0, step_ff};
      w_low     = w_ff[Q8_W-1:0];
      clipped   = w_ff >= QUO_W'(SCREEN_Q8);

      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      w_in      = w_ff;
      mcand_in  = mcand_ff;
      prod_in   = prod_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      col_in    = col_ff;
      srow_in   = srow_ff;
      trow_in   = trow_ff;
      tcol_in   = tcol_ff;
      last_in   = last_ff;

      if (cmd.load_w) begin
         rem_in = '0;
         quo_in = {projection_constant, 8'd0};
         dvs_in = (ray_distance == '0) ? QUO_W'(1) : QUO_W'(ray_distance);
         col_in = texture_column;
      end
      if (cmd.div_step) begin
         rem_in = ge ? diff[QUO_W-1:0] : shifted[QUO_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
      end
      if (cmd.load_s) begin
         // second division: texture height in Q.24 over the wall height
         w_in   = quo_ff;
         dvs_in = quo_ff;
         rem_in = '0;
         quo_in = QUO_W'(th_eff) << 24;
      end
      if (cmd.load_m) begin
         // product stays below 2^35 whenever the wall is clipped
         step_in   = sat_step(quo_ff);
         mplier_in = sat_step(quo_ff);
         mcand_in  = mcand_src[PROD_W-1:0];
         prod_in   = '0;
      end
      if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[ACC_W-1:1]};
      end
      if (cmd.commit) begin
         if (clipped) begin
            acc_in  = prod_ff[PROD_W-1:9];
            row_in  = '0;
            left_in = LEFT_W'(SCREEN_ROWS - 1);
         end else begin
            acc_in  = '0;
            row_in  = SROW_W'((Q8_W'(SCREEN_Q8) - w_low) >> 9);
            left_in = LEFT_W'((w_low + Q8_W'(255)) >> 8);
         end
      end
      if (cmd.row_advance) begin
         srow_in = row_ff;
         trow_in = (acc_int > limit) ? limit : acc_int;
         tcol_in = col_ff;
         last_in = left_ff == LEFT_W'(1);
         acc_in  = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
         row_in  = row_ff + SROW_W'(1);
         left_in = left_ff - LEFT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         step_ff <= '0;
         row_ff  <= '0;
         left_ff <= '0;
         col_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
         step_ff <= step_in;
         row_ff  <= row_in;
         left_ff <= left_in;
         col_ff  <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dvs_ff    <= dvs_in;
      w_ff      <= w_in;
      mcand_ff  <= mcand_in;
      prod_ff   <= prod_in;
      mplier_ff <= mplier_in;
      srow_ff   <= srow_in;
      trow_ff   <= trow_in;
      tcol_ff   <= tcol_in;
      last_ff   <= last_in;
   end

   assign status.rows_zero  = left_ff == '0;
   assign screen_row        = srow_ff;
   assign texture_row       = trow_ff;
   assign column_of_texture = tcol_ff;
   assign last              = last_ff;

endmodule

>>> rtl/core/wcts_ctrl.sv
`timescale 1ns / 1ps
module wcts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  wcts_pkg::status_type status,
   output wcts_pkg::cmd_type    cmd
);
   import wcts_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DIV_W  = 7'b0000010,
      ST_LOAD_S = 7'b0000100,
      ST_DIV_S  = 7'b0001000,
      ST_LOAD_M = 7'b0010000,
      ST_MUL    = 7'b0100000,
      ST_COMMIT = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             div_last, mul_last;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign div_last  = cnt_ff == CNT_W'(DIV_STEPS - 1);
   assign mul_last  = cnt_ff == CNT_W'(MUL_STEPS - 1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !req_mode) begin
               cmd.load_w = 1'b1;
               cnt_in     = '0;
               state_in   = ST_DIV_W;
            end else if (accept && !status.rows_zero) begin
               cmd.row_advance = 1'b1;
            end
         end
         ST_DIV_W: begin
            cmd.div_step = 1'b1;
            cnt_in       = div_last ? '0 : cnt_ff + CNT_W'(1);
            if (div_last) begin
               state_in = ST_LOAD_S;
            end
         end
         ST_LOAD_S: begin
            cmd.load_s = 1'b1;
            state_in   = ST_DIV_S;
         end
         ST_DIV_S: begin
            cmd.div_step = 1'b1;
            cnt_in       = div_last ? '0 : cnt_ff + CNT_W'(1);
            if (div_last) begin
               state_in = ST_LOAD_M;
            end
         end
         ST_LOAD_M: begin
            cmd.load_m = 1'b1;
            cnt_in     = '0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = mul_last ? '0 : cnt_ff + CNT_W'(1);
            if (mul_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a new beat loads the output register, otherwise it drains on ready
      if (cmd.row_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`include "wall_column_texture_stepper_top_assert.svh"

   `WCTS_ASSERT_SAME(a_row_slot_free, clock, reset, cmd.row_advance, !rsp_valid_ff || rsp_ready)
   `WCTS_ASSERT_NEXT(a_div_w_to_s, clock, reset, (state_ff == ST_DIV_W) && div_last, state_ff == ST_LOAD_S)
   `WCTS_ASSERT_NEXT(a_commit_idle, clock, reset, state_ff == ST_COMMIT, state_ff == ST_IDLE)

endmodule
